@@ sv/assert_macros.svh @@
// Assertion macros used by the rotation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLKED(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Simple same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/arcball_pkg.sv @@
// Constants, types and the arctangent table of the arcball rotation core.
package arcball_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int VEC_W       = 16;
   localparam int ONE_INT     = 1 << FRAC_BITS;
   localparam int ACC_W       = 32;
   localparam int ROOT_W      = 30;
   localparam int ROOT_TOP    = ROOT_W - 2;
   localparam int DIV_STEPS   = 16;
   localparam int ROOT_STEPS  = 15;
   localparam int ANGLE_ITERS = 40;
   localparam int CORDIC_BITS = 30;
   localparam int CORDIC_SH   = CORDIC_BITS - FRAC_BITS;
   localparam int CORD_W      = 34;
   localparam int ANGLE_SHIFT = 60 - FRAC_BITS;
   localparam int CNT_W       = 6;
   localparam int CSR_IDX_W   = 4;

   localparam logic signed [VEC_W-1:0] ONE     = VEC_W'(ONE_INT);
   localparam logic        [VEC_W-1:0] ONE_U   = VEC_W'(ONE_INT);
   localparam logic        [ROOT_W-1:0] ONE_SQ = ROOT_W'(ONE_INT * ONE_INT);
   localparam logic        [VEC_W-1:0] ANGLE_MAX = 16'd51472;

   localparam logic [VEC_W-1:0] WIDTH_RESET  = 16'd1920;
   localparam logic [VEC_W-1:0] HEIGHT_RESET = 16'd1080;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 4'd1;

   typedef logic signed [63:0] q60_type;
   typedef q60_type atan_tab_type [ANGLE_ITERS];

   // atan(2^-sh) in Q60 by its alternating series, sh >= 1.
   function automatic q60_type atan_pow2(input int sh);
      logic [63:0] term;
      logic [63:0] t;
      q60_type     sum;
      int          k;
      term = 64'd1 << (60 - sh);
      sum  = '0;
      k    = 0;
      while (term != 64'd0) begin
         t = term / 64'(2 * k + 1);
         if (k % 2 == 1) begin
            sum = sum - $signed(t);
         end else begin
            sum = sum + $signed(t);
         end
         term = term >> (2 * sh);
         k    = k + 1;
      end
      return sum;
   endfunction

   // atan(1/3) in Q60.
   function automatic q60_type atan_third();
      logic [63:0] term;
      logic [63:0] t;
      q60_type     sum;
      int          k;
      term = (64'd1 << 60) / 3;
      sum  = '0;
      k    = 0;
      while (term != 64'd0) begin
         t = term / 64'(2 * k + 1);
         if (k % 2 == 1) begin
            sum = sum - $signed(t);
         end else begin
            sum = sum + $signed(t);
         end
         term = term / 9;
         k    = k + 1;
      end
      return sum;
   endfunction

   function automatic atan_tab_type build_atan_tab();
      atan_tab_type tab;
      tab[0] = atan_pow2(1) + atan_third();
      for (int i = 1; i < ANGLE_ITERS; i++) begin
         tab[i] = atan_pow2(i);
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan_tab();
   localparam q60_type      PI_Q60   = ATAN_TAB[0] * 4;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOAD  = 9'b000000010,
      ST_DIV   = 9'b000000100,
      ST_SQSUM = 9'b000001000,
      ST_ROOT  = 9'b000010000,
      ST_POINT = 9'b000100000,
      ST_MUL   = 9'b001000000,
      ST_CORD  = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      JOB_MAPX  = 2'd0,
      JOB_MAPY  = 2'd1,
      JOB_NORMR = 2'd2,
      JOB_NORMU = 2'd3
   } job_type;

endpackage

@@ sv/arcball_if.sv @@
// Channel interfaces of the arcball rotation core.
interface arcball_req_if;
   import arcball_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic signed [VEC_W-1:0] pointer_x;
   logic signed [VEC_W-1:0] pointer_y;
   modport source (output valid, operation, pointer_x, pointer_y, input ready);
   modport sink   (input valid, operation, pointer_x, pointer_y, output ready);
endinterface

interface arcball_rsp_if;
   import arcball_pkg::*;
   logic                    valid;
   logic                    ready;
   logic        [VEC_W-1:0] rotation_angle;
   logic signed [VEC_W-1:0] axis_forward;
   logic signed [VEC_W-1:0] axis_right;
   logic signed [VEC_W-1:0] axis_up;
   modport source (output valid, rotation_angle, axis_forward, axis_right, axis_up,
                   input ready);
   modport sink   (input valid, rotation_angle, axis_forward, axis_right, axis_up,
                   output ready);
endinterface

interface arcball_csr_if;
   import arcball_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VEC_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/arcball_rotation_from_pointer_core.sv @@
// Arcball rotation core: pointer events in, rotation angle and axis out.
//
//   channel   dir  contents
//   req_ch    in   operation, pointer_x, pointer_y
//   rsp_ch    out  rotation_angle, axis_forward, axis_right, axis_up
//   csr_ch    in   index, data (window_width, window_height)
//
// A press maps the pointer onto the sphere, normalising when the point falls outside the unit circle.
// A drag goes on with the products, the angle root and 40 CORDIC steps.
// One restoring divider, one square root unit and one 16x16 multiplier are reused.
// Synchronous reset sets the window to 1920x1080 and the start point to zero.
// The result sits in an output register; a new result waits only if it is untaken.
`include "assert_macros.svh"

module arcball_rotation_from_pointer_core (
   input logic             clock,
   input logic             reset,
   arcball_req_if.sink     req_ch,
   arcball_rsp_if.source   rsp_ch,
   arcball_csr_if.sink     csr_ch
);
   import arcball_pkg::*;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic                    op_ff, op_in;
   logic signed [VEC_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [VEC_W-1:0] width_ff, width_in, height_ff, height_in;

   logic signed [VEC_W-1:0] start_f_ff, start_f_in, start_r_ff, start_r_in;
   logic signed [VEC_W-1:0] start_u_ff, start_u_in;
   logic signed [VEC_W-1:0] cur_f_ff, cur_f_in, cur_r_ff, cur_r_in, cur_u_ff, cur_u_in;

   logic [ACC_W-1:0] div_n_ff, div_n_in;
   logic [VEC_W-1:0] div_d_ff, div_d_in, div_q_ff, div_q_in;
   logic             div_neg_ff, div_neg_in, div_sat_ff, div_sat_in;
   logic [VEC_W-1:0] len_ff, len_in;

   logic [ROOT_W-1:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic              root_acos_ff, root_acos_in, inside_ff, inside_in;

   logic signed [ACC_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic                    mul_sub_ff, mul_sub_in;
   logic signed [VEC_W-1:0] mul_a, mul_b;

   logic signed [VEC_W-1:0] dot_ff, dot_in, ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [CORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   q60_type                  cz_ff, cz_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VEC_W-1:0]        out_ang_ff, out_ang_in;
   logic signed [VEC_W-1:0] out_f_ff, out_f_in, out_r_ff, out_r_in, out_u_ff, out_u_in;

   // Helper signals.
   logic [VEC_W-1:0]        w_eff, h_eff, map_den;
   logic signed [17:0]      num_x, num_y, num_sel;
   logic [16:0]             map_mag;
   logic signed [VEC_W-1:0] norm_src;
   logic [VEC_W-1:0]        norm_mag;
   logic [16:0]             div_t;
   logic                    div_ge;
   logic [VEC_W-1:0]        div_qmag;
   logic signed [VEC_W-1:0] div_val;
   logic [ROOT_W-1:0]       sq_sum;
   logic                    sq_ge;
   logic signed [ACC_W-1:0] sprod;
   logic signed [VEC_W-1:0] acc_scaled;
   logic signed [VEC_W-1:0] dot_abs;
   logic signed [CORD_W-1:0] cx_sh, cy_sh;
   q60_type                 z_pos, z_full, z_round;

   function automatic logic signed [VEC_W-1:0] scale_clamp(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      // Truncate toward zero on the division by one.
      t = a[ACC_W-1] ? ((a + ACC_W'(ONE_INT - 1)) >>> FRAC_BITS) : (a >>> FRAC_BITS);
      if (t > ACC_W'(ONE_INT)) begin
         return ONE;
      end else if (t < -ACC_W'(ONE_INT)) begin
         return -ONE;
      end
      return t[VEC_W-1:0];
   endfunction

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.rotation_angle = out_ang_ff;
   assign rsp_ch.axis_forward   = out_f_ff;
   assign rsp_ch.axis_right     = out_r_ff;
   assign rsp_ch.axis_up        = out_u_ff;

   // A zero window size counts as one pixel.
   assign w_eff = (width_ff == '0) ? VEC_W'(1) : width_ff;
   assign h_eff = (height_ff == '0) ? VEC_W'(1) : height_ff;

   assign num_x   = {px_ff[VEC_W-1], px_ff, 1'b0} - $signed({2'b00, w_eff});
   assign num_y   = $signed({2'b00, h_eff}) - {py_ff[VEC_W-1], py_ff, 1'b0};
   assign num_sel = (job_ff == JOB_MAPX) ? num_x : num_y;
   assign map_den = (job_ff == JOB_MAPX) ? w_eff : h_eff;
   assign map_mag = num_sel[17] ? 17'(-num_sel) : num_sel[16:0];

   assign norm_src = (job_ff == JOB_NORMR) ? cur_r_ff : cur_u_ff;
   assign norm_mag = norm_src[VEC_W-1] ? VEC_W'(-norm_src) : norm_src;

   // One restoring division step.
   assign div_t  = {div_n_ff[ACC_W-1:VEC_W], div_n_ff[VEC_W-1]};
   assign div_ge = div_t >= {1'b0, div_d_ff};
   assign div_qmag = div_sat_ff ? ONE_U : ((div_q_ff > ONE_U) ? ONE_U : div_q_ff);
   assign div_val  = div_neg_ff ? -$signed(div_qmag) : $signed(div_qmag);

   // One digit of the bitwise square root.
   assign sq_sum = sq_res_ff + sq_bit_ff;
   assign sq_ge  = sq_v_ff >= sq_sum;

   assign sprod      = mul_sub_ff ? -prod_ff : prod_ff;
   assign acc_scaled = scale_clamp(acc_ff);
   assign dot_abs    = dot_ff[VEC_W-1] ? -dot_ff : dot_ff;

   assign cx_sh = cx_ff >>> cnt_ff;
   assign cy_sh = cy_ff >>> cnt_ff;

   assign z_pos   = cz_ff[63] ? '0 : cz_ff;
   assign z_full  = dot_ff[VEC_W-1] ? (PI_Q60 - z_pos) : z_pos;
   assign z_round = z_full + (q60_type'(1) <<< (ANGLE_SHIFT - 1));

   // Shared multiplier operands.
   always_comb begin
      mul_a      = cur_r_ff;
      mul_b      = cur_r_ff;
      mul_sub_in = 1'b0;
      if (state_ff == ST_SQSUM) begin
         if (cnt_ff != '0) begin
            mul_a = cur_u_ff;
            mul_b = cur_u_ff;
         end
      end else begin
         case (cnt_ff)
            6'd0: begin mul_a = start_f_ff; mul_b = cur_f_ff; end
            6'd1: begin mul_a = start_r_ff; mul_b = cur_r_ff; end
            6'd2: begin mul_a = start_u_ff; mul_b = cur_u_ff; end
            6'd3: begin mul_a = start_r_ff; mul_b = cur_u_ff; end
            6'd4: begin mul_a = start_u_ff; mul_b = cur_r_ff; mul_sub_in = 1'b1; end
            6'd5: begin mul_a = start_u_ff; mul_b = cur_f_ff; end
            6'd6: begin mul_a = start_f_ff; mul_b = cur_u_ff; mul_sub_in = 1'b1; end
            6'd7: begin mul_a = start_f_ff; mul_b = cur_r_ff; end
            6'd8: begin mul_a = start_r_ff; mul_b = cur_f_ff; mul_sub_in = 1'b1; end
            6'd9: begin mul_a = dot_abs;    mul_b = dot_abs;  end
            default: begin end
         endcase
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      start_f_in   = start_f_ff;
      start_r_in   = start_r_ff;
      start_u_in   = start_u_ff;
      cur_f_in     = cur_f_ff;
      cur_r_in     = cur_r_ff;
      cur_u_in     = cur_u_ff;
      div_n_in     = div_n_ff;
      div_d_in     = div_d_ff;
      div_q_in     = div_q_ff;
      div_neg_in   = div_neg_ff;
      div_sat_in   = div_sat_ff;
      len_in       = len_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      root_acos_in = root_acos_ff;
      inside_in    = inside_ff;
      acc_in       = acc_ff;
      dot_in       = dot_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      rsp_valid_in = rsp_valid_ff;
      out_ang_in   = out_ang_ff;
      out_f_in     = out_f_ff;
      out_r_in     = out_r_ff;
      out_u_in     = out_u_ff;

      if (csr_ch.valid) begin
         if (csr_ch.index == CSR_WIDTH) begin
            width_in = csr_ch.data;
         end else if (csr_ch.index == CSR_HEIGHT) begin
            height_in = csr_ch.data;
         end
      end

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               px_in    = req_ch.pointer_x;
               py_in    = req_ch.pointer_y;
               job_in   = JOB_MAPX;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in   = '0;
            div_q_in = '0;
            if (job_ff == JOB_MAPX || job_ff == JOB_MAPY) begin
               // At or past twice the window the quotient clamps; the divide runs on a zero dividend.
               div_sat_in = map_mag >= {map_den, 1'b0};
               div_n_in   = div_sat_in ? '0 : (ACC_W'(map_mag) << FRAC_BITS);
               div_d_in   = map_den;
               div_neg_in = num_sel[17];
            end else begin
               div_sat_in = 1'b0;
               div_n_in   = ACC_W'(norm_mag) << FRAC_BITS;
               div_d_in   = len_ff;
               div_neg_in = norm_src[VEC_W-1];
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               cnt_in = '0;
               case (job_ff)
                  JOB_MAPX: begin
                     cur_r_in = div_val;
                     job_in   = JOB_MAPY;
                     state_in = ST_LOAD;
                  end
                  JOB_MAPY: begin
                     cur_u_in = div_val;
                     state_in = ST_SQSUM;
                  end
                  JOB_NORMR: begin
                     cur_r_in = div_val;
                     job_in   = JOB_NORMU;
                     state_in = ST_LOAD;
                  end
                  default: begin
                     cur_u_in = div_val;
                     state_in = ST_POINT;
                  end
               endcase
            end else begin
               div_n_in = {(div_ge ? 16'(div_t - {1'b0, div_d_ff}) : div_t[VEC_W-1:0]),
                           div_n_ff[VEC_W-2:0], 1'b0};
               div_q_in = {div_q_ff[VEC_W-2:0], div_ge};
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ST_SQSUM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd1) begin
               acc_in = prod_ff;
            end else if (cnt_ff == 6'd2) begin
               acc_in = acc_ff + prod_ff;
            end else if (cnt_ff == 6'd3) begin
               inside_in    = acc_ff <= $signed({2'b00, ONE_SQ});
               sq_v_in      = inside_in ? (ONE_SQ - acc_ff[ROOT_W-1:0]) : acc_ff[ROOT_W-1:0];
               sq_res_in    = '0;
               sq_bit_in    = ROOT_W'(1) << ROOT_TOP;
               root_acos_in = 1'b0;
               cnt_in       = '0;
               state_in     = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(ROOT_STEPS)) begin
               cnt_in = '0;
               if (root_acos_ff) begin
                  cx_in    = CORD_W'(dot_abs) <<< CORDIC_SH;
                  cy_in    = $signed(CORD_W'(sq_res_ff)) <<< CORDIC_SH;
                  cz_in    = '0;
                  state_in = ST_CORD;
               end else if (inside_ff) begin
                  cur_f_in = $signed(sq_res_ff[VEC_W-1:0]);
                  state_in = ST_POINT;
               end else begin
                  // Outside the circle the point moves onto the rim.
                  cur_f_in = '0;
                  len_in   = sq_res_ff[VEC_W-1:0];
                  job_in   = JOB_NORMR;
                  state_in = ST_LOAD;
               end
            end else begin
               sq_v_in   = sq_ge ? (sq_v_ff - sq_sum) : sq_v_ff;
               sq_res_in = sq_ge ? ((sq_res_ff >> 1) + sq_bit_ff) : (sq_res_ff >> 1);
               sq_bit_in = sq_bit_ff >> 2;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         ST_POINT: begin
            cnt_in = '0;
            if (!op_ff) begin
               start_f_in = cur_f_ff;
               start_r_in = cur_r_ff;
               start_u_in = cur_u_ff;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // Products land in the cycle after issue; each sum is scaled once complete.
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd1 || cnt_ff == 6'd4 || cnt_ff == 6'd6 || cnt_ff == 6'd8) begin
               acc_in = sprod;
            end else if (cnt_ff != '0 && cnt_ff != 6'd10) begin
               acc_in = acc_ff + sprod;
            end
            case (cnt_ff)
               6'd4: dot_in = acc_scaled;
               6'd6: ax_in  = acc_scaled;
               6'd8: ay_in  = acc_scaled;
               6'd10: begin
                  az_in        = acc_scaled;
                  sq_v_in      = ONE_SQ - prod_ff[ROOT_W-1:0];
                  sq_res_in    = '0;
                  sq_bit_in    = ROOT_W'(1) << ROOT_TOP;
                  root_acos_in = 1'b1;
                  cnt_in       = '0;
                  state_in     = ST_ROOT;
               end
               default: begin end
            endcase
         end
         ST_CORD: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + cy_sh;
               cy_in = cy_ff - cx_sh;
               cz_in = cz_ff + ATAN_TAB[cnt_ff];
            end else begin
               cx_in = cx_ff - cy_sh;
               cy_in = cy_ff + cx_sh;
               cz_in = cz_ff - ATAN_TAB[cnt_ff];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ANGLE_ITERS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_ang_in   = z_round[ANGLE_SHIFT +: VEC_W];
               out_f_in     = ax_ff;
               out_r_in     = ay_ff;
               out_u_in     = az_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_MAPX;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         start_f_ff   <= '0;
         start_r_ff   <= '0;
         start_u_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         start_f_ff   <= start_f_in;
         start_r_ff   <= start_r_in;
         start_u_ff   <= start_u_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      cur_f_ff     <= cur_f_in;
      cur_r_ff     <= cur_r_in;
      cur_u_ff     <= cur_u_in;
      div_n_ff     <= div_n_in;
      div_d_ff     <= div_d_in;
      div_q_ff     <= div_q_in;
      div_neg_ff   <= div_neg_in;
      div_sat_ff   <= div_sat_in;
      len_ff       <= len_in;
      sq_v_ff      <= sq_v_in;
      sq_res_ff    <= sq_res_in;
      sq_bit_ff    <= sq_bit_in;
      root_acos_ff <= root_acos_in;
      inside_ff    <= inside_in;
      prod_ff      <= prod_in;
      mul_sub_ff   <= mul_sub_in;
      acc_ff       <= acc_in;
      dot_ff       <= dot_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      az_ff        <= az_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      out_ang_ff   <= out_ang_in;
      out_f_ff     <= out_f_in;
      out_r_ff     <= out_r_in;
      out_u_ff     <= out_u_in;
   end

   `ASSERT_IMPLY(a_angle_range, clock, reset, rsp_ch.valid, rsp_ch.rotation_angle <= ANGLE_MAX, "rotation angle above pi")
   `ASSERT_CLKED(a_busy_after_transfer, clock, reset, (req_ch.valid && req_ch.ready) |=> (state_ff != ST_IDLE), "core idle right after an input transfer")
   `ASSERT_IMPLY(a_point_in_range, clock, reset, state_ff == ST_MUL, (cur_r_ff <= ONE) && (cur_r_ff >= -ONE) && (cur_u_ff <= ONE) && (cur_u_ff >= -ONE), "mapped point outside the unit square")

endmodule
